// ===== sv/rmms_pkg.sv =====
// Shared constants and types for the running min/max/mean/deviation block.
package rmms_pkg;

  localparam int unsigned SAMPLE_WIDTH_DEF = 16;
  localparam int unsigned COUNT_WIDTH_DEF  = 16;
  localparam int unsigned ROW_WIDTH        = 16;
  localparam int unsigned FRAC_BITS        = 8;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_EMPTY    = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    FIN_IDLE,
    FIN_MUL_N,
    FIN_MUL_MAG,
    FIN_SQRT,
    FIN_MEAN_ADD,
    FIN_MEAN_DIV,
    FIN_DEV_DIV,
    FIN_DONE
  } fin_state_e;

  typedef struct packed {
    logic                 close;
    logic                 last;
    logic                 overflow;
    logic [ROW_WIDTH-1:0] row;
  } close_t;

endpackage

// ===== sv/running_min_max_mean_stddev_top.sv =====
// Top level of the running min/max/mean/stddev block: accumulator, finisher, result register.
//
//  channel  dir  tdata (low bit up)                              tuser                 tlast
//  s_axis   in   sample_value                                    has_sample, row_end   set_end
//  m_axis   out  minimum, maximum, spread, mean_q8, deviation_q8, status              last
//                sample_count, row_number
//  cfg      in   cfg_wdata_i = per_row_mode, written when cfg_we_i is high
//
// An item that closes no group leaves s_axis_tready high. An item that closes a group
// holds s_axis_tready low from its accept while the finisher runs its shared adder, and
// until its result is taken; an empty group goes straight to its result.
// One result can wait in the output register while m_axis stalls; a second finished
// result holds the finisher, and with it s_axis_tready, until that register frees.
// Reset clears all statistics, the row counter and per_row_mode.
module running_min_max_mean_stddev_top import rmms_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int unsigned COUNT_WIDTH  = COUNT_WIDTH_DEF,
  localparam int unsigned IN_W  = ((SAMPLE_WIDTH + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((5*SAMPLE_WIDTH + COUNT_WIDTH + 2*FRAC_BITS + ROW_WIDTH + 7)
                                   / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,   // sample_value
  input  logic [1:0]       s_axis_tuser,   // has_sample, row_end
  input  logic             s_axis_tlast,   // set_end
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,   // min, max, spread, mean, dev, count, row
  output logic [1:0]       m_axis_tuser,   // status
  output logic             m_axis_tlast    // last
);

  localparam int unsigned SUM_W = SAMPLE_WIDTH + COUNT_WIDTH;
  localparam int unsigned SQ_W  = 2*SAMPLE_WIDTH + COUNT_WIDTH;
  localparam int unsigned Q_W   = SAMPLE_WIDTH + FRAC_BITS;

  logic                           item_acc;
  close_t                         close;
  logic signed [SAMPLE_WIDTH-1:0] acc_min, acc_max;
  logic [SUM_W-1:0]               acc_sum;
  logic [SQ_W-1:0]                acc_sumsq;
  logic [COUNT_WIDTH-1:0]         acc_count;

  logic                    fin_idle, fin_valid, load;
  status_e                 res_status;
  logic [SAMPLE_WIDTH-1:0] res_min, res_max, res_spread;
  logic [Q_W-1:0]          res_mean, res_dev;
  logic [COUNT_WIDTH-1:0]  res_count;
  logic [ROW_WIDTH-1:0]    res_row;
  logic                    res_last;

  logic             out_valid_q;
  logic [OUT_W-1:0] out_data_q;
  logic [1:0]       out_user_q;
  logic             out_last_q;

  assign s_axis_tready = fin_idle;
  assign item_acc      = s_axis_tvalid & fin_idle;

  rmms_accum #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_acc_i   (item_acc),
    .sample_i     (s_axis_tdata[SAMPLE_WIDTH-1:0]),
    .has_sample_i (s_axis_tuser[0]),
    .row_end_i    (s_axis_tuser[1]),
    .set_end_i    (s_axis_tlast),
    .close_o      (close),
    .min_o        (acc_min),
    .max_o        (acc_max),
    .sum_o        (acc_sum),
    .sumsq_o      (acc_sumsq),
    .count_o      (acc_count)
  );

  rmms_finish #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_finish (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .close_i     (close),
    .min_i       (acc_min),
    .max_i       (acc_max),
    .sum_i       (acc_sum),
    .sumsq_i     (acc_sumsq),
    .count_i     (acc_count),
    .idle_o      (fin_idle),
    .res_valid_o (fin_valid),
    .res_take_i  (load),
    .status_o    (res_status),
    .min_o       (res_min),
    .max_o       (res_max),
    .spread_o    (res_spread),
    .mean_o      (res_mean),
    .dev_o       (res_dev),
    .count_o     (res_count),
    .row_o       (res_row),
    .last_o      (res_last)
  );

  assign load = fin_valid & (~out_valid_q | m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q <= OUT_W'({res_row, res_count, res_dev, res_mean,
                            res_spread, res_max, res_min});
      out_user_q <= res_status;
      out_last_q <= res_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// ===== sv/rmms_accum.sv =====
// Group accumulator: min, max, sum, sum of squares, saturating count, row counter, mode.
module rmms_accum import rmms_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int unsigned COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       cfg_we_i,
  input  logic                                       cfg_wdata_i,
  input  logic                                       item_acc_i,
  input  logic signed [SAMPLE_WIDTH-1:0]             sample_i,
  input  logic                                       has_sample_i,
  input  logic                                       row_end_i,
  input  logic                                       set_end_i,
  output close_t                                     close_o,
  output logic signed [SAMPLE_WIDTH-1:0]             min_o,
  output logic signed [SAMPLE_WIDTH-1:0]             max_o,
  output logic [SAMPLE_WIDTH+COUNT_WIDTH-1:0]        sum_o,
  output logic [2*SAMPLE_WIDTH+COUNT_WIDTH-1:0]      sumsq_o,
  output logic [COUNT_WIDTH-1:0]                     count_o
);

  localparam int unsigned SUM_W = SAMPLE_WIDTH + COUNT_WIDTH;
  localparam int unsigned SQ_W  = 2*SAMPLE_WIDTH + COUNT_WIDTH;

  localparam logic signed [SAMPLE_WIDTH-1:0] SMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic                           mode_q;
  logic signed [SAMPLE_WIDTH-1:0] min_q, min_d, max_q, max_d;
  logic [SUM_W-1:0]               sum_q, sum_d;
  logic [SQ_W-1:0]                sumsq_q, sumsq_d;
  logic [COUNT_WIDTH-1:0]         count_q, count_d;
  logic                           ovf_q, ovf_d;
  logic [ROW_WIDTH-1:0]           row_q, row_d;
  logic [SAMPLE_WIDTH-1:0]        smag;
  logic [2*SAMPLE_WIDTH-1:0]      sq;
  logic                           close;

  assign smag  = sample_i[SAMPLE_WIDTH-1] ? (~sample_i + 1'b1) : sample_i;
  assign sq    = smag * smag;
  assign close = item_acc_i & (mode_q ? (row_end_i | set_end_i) : set_end_i);

  always_comb begin
    min_d   = min_q;
    max_d   = max_q;
    sum_d   = sum_q;
    sumsq_d = sumsq_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    if (item_acc_i && has_sample_i) begin
      if (sample_i < min_q) begin
        min_d = sample_i;
      end
      if (sample_i > max_q) begin
        max_d = sample_i;
      end
      if (count_q == '1) begin
        ovf_d = 1'b1;
      end else begin
        sum_d   = sum_q + {{COUNT_WIDTH{sample_i[SAMPLE_WIDTH-1]}}, sample_i};
        sumsq_d = sumsq_q + SQ_W'(sq);
        count_d = count_q + 1'b1;
      end
    end
    row_d = row_q;
    if (item_acc_i) begin
      if (set_end_i) begin
        row_d = '0;
      end else if (mode_q && row_end_i) begin
        row_d = row_q + 1'b1;
      end
    end
  end

  assign close_o.close    = close;
  assign close_o.last     = set_end_i;
  assign close_o.overflow = ovf_d;
  assign close_o.row      = mode_q ? row_q : '0;
  assign min_o   = min_d;
  assign max_o   = max_d;
  assign sum_o   = sum_d;
  assign sumsq_o = sumsq_d;
  assign count_o = count_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      min_q   <= SMAX;
      max_q   <= SMIN;
      sum_q   <= '0;
      sumsq_q <= '0;
      count_q <= '0;
      ovf_q   <= 1'b0;
      row_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      row_q <= row_d;
      if (close) begin
        min_q   <= SMAX;
        max_q   <= SMIN;
        sum_q   <= '0;
        sumsq_q <= '0;
        count_q <= '0;
        ovf_q   <= 1'b0;
      end else begin
        min_q   <= min_d;
        max_q   <= max_d;
        sum_q   <= sum_d;
        sumsq_q <= sumsq_d;
        count_q <= count_d;
        ovf_q   <= ovf_d;
      end
    end
  end

endmodule

// ===== sv/rmms_finish.sv =====
// Group finisher: sequencer around one shared add/subtract unit (mul, isqrt, divides).
module rmms_finish import rmms_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int unsigned COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  close_t                                     close_i,
  input  logic signed [SAMPLE_WIDTH-1:0]             min_i,
  input  logic signed [SAMPLE_WIDTH-1:0]             max_i,
  input  logic [SAMPLE_WIDTH+COUNT_WIDTH-1:0]        sum_i,
  input  logic [2*SAMPLE_WIDTH+COUNT_WIDTH-1:0]      sumsq_i,
  input  logic [COUNT_WIDTH-1:0]                     count_i,
  output logic                                       idle_o,
  output logic                                       res_valid_o,
  input  logic                                       res_take_i,
  output status_e                                    status_o,
  output logic [SAMPLE_WIDTH-1:0]                    min_o,
  output logic [SAMPLE_WIDTH-1:0]                    max_o,
  output logic [SAMPLE_WIDTH-1:0]                    spread_o,
  output logic [SAMPLE_WIDTH+FRAC_BITS-1:0]          mean_o,
  output logic [SAMPLE_WIDTH+FRAC_BITS-1:0]          dev_o,
  output logic [COUNT_WIDTH-1:0]                     count_o,
  output logic [ROW_WIDTH-1:0]                       row_o,
  output logic                                       last_o
);

  localparam int unsigned SUM_W = SAMPLE_WIDTH + COUNT_WIDTH;
  localparam int unsigned SQ_W  = 2*SAMPLE_WIDTH + COUNT_WIDTH;
  localparam int unsigned D_W   = 2*SAMPLE_WIDTH + 2*COUNT_WIDTH;
  localparam int unsigned R_W   = D_W/2 + FRAC_BITS;
  localparam int unsigned RM_W  = R_W + 2;
  localparam int unsigned NW1   = SUM_W + FRAC_BITS + 2;
  localparam int unsigned Q_W   = SAMPLE_WIDTH + FRAC_BITS;
  localparam int unsigned AW    = D_W;
  localparam int unsigned CNT_W = $clog2(NW1);

  fin_state_e state_q, state_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [COUNT_WIDTH-1:0]  n_q, n_d;
  logic [SQ_W-1:0]         sumsq_q, sumsq_d;
  logic [SUM_W-1:0]        mag_q, mag_d, sum_mag;
  logic                    neg_q, neg_d;
  logic [SAMPLE_WIDTH-1:0] min_q, min_d, max_q, max_d;
  logic                    ovf_q, ovf_d, last_q, last_d, empty_q, empty_d;
  logic [ROW_WIDTH-1:0]    row_q, row_d;
  logic [D_W-1:0]          acc_q, acc_d, aux_q, aux_d;
  logic [R_W-1:0]          root_q, root_d;
  logic [RM_W-1:0]         rem_q, rem_d;
  logic [NW1-1:0]          quo_q, quo_d, q_next, q_neg;
  logic [COUNT_WIDTH:0]    div_q, div_d;
  logic [Q_W-1:0]          mean_q, mean_d;

  logic [AW-1:0] alu_a, alu_b;
  logic          alu_sub;
  logic [AW:0]   alu_r;
  logic          ge;
  logic          cnt_end;

  assign sum_mag = sum_i[SUM_W-1] ? (~sum_i + 1'b1) : sum_i;
  assign cnt_end = (cnt_q == '0);

  // shared adder: carry out high on subtract means a >= b
  assign alu_r = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (AW+1)'(alu_sub);
  assign ge    = alu_r[AW];

  assign q_next = {quo_q[NW1-2:0], ge};
  assign q_neg  = ~q_next + 1'b1;

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_q)
      FIN_MUL_N: begin
        alu_a = acc_q << 1;
        alu_b = quo_q[COUNT_WIDTH-1] ? AW'(sumsq_q) : '0;
      end
      FIN_MUL_MAG: begin
        alu_a   = acc_q;
        alu_b   = rem_q[0] ? aux_q : '0;
        alu_sub = 1'b1;
      end
      FIN_SQRT: begin
        alu_a   = AW'({rem_q[RM_W-3:0], acc_q[D_W-1:D_W-2]});
        alu_b   = AW'({root_q, 2'b01});
        alu_sub = 1'b1;
      end
      FIN_MEAN_ADD: begin
        alu_a = AW'({mag_q, {(FRAC_BITS+1){1'b0}}});
        alu_b = AW'(n_q);
      end
      FIN_MEAN_DIV, FIN_DEV_DIV: begin
        alu_a   = AW'({rem_q[RM_W-2:0], quo_q[NW1-1]});
        alu_b   = AW'(div_q);
        alu_sub = 1'b1;
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    n_d     = n_q;
    sumsq_d = sumsq_q;
    mag_d   = mag_q;
    neg_d   = neg_q;
    min_d   = min_q;
    max_d   = max_q;
    ovf_d   = ovf_q;
    last_d  = last_q;
    empty_d = empty_q;
    row_d   = row_q;
    acc_d   = acc_q;
    aux_d   = aux_q;
    root_d  = root_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    div_d   = div_q;
    mean_d  = mean_q;
    case (state_q)
      FIN_IDLE: begin
        if (close_i.close) begin
          n_d     = count_i;
          sumsq_d = sumsq_i;
          neg_d   = sum_i[SUM_W-1];
          mag_d   = sum_mag;
          min_d   = min_i;
          max_d   = max_i;
          ovf_d   = close_i.overflow;
          last_d  = close_i.last;
          row_d   = close_i.row;
          empty_d = (count_i == '0);
          acc_d   = '0;
          quo_d   = NW1'(count_i);
          aux_d   = D_W'(sum_mag);
          rem_d   = RM_W'(sum_mag);
          cnt_d   = CNT_W'(COUNT_WIDTH - 1);
          state_d = (count_i == '0) ? FIN_DONE : FIN_MUL_N;
        end
      end
      FIN_MUL_N: begin
        acc_d = alu_r[AW-1:0];
        quo_d = quo_q << 1;
        cnt_d = cnt_q - 1'b1;
        if (cnt_end) begin
          cnt_d   = CNT_W'(SUM_W - 1);
          state_d = FIN_MUL_MAG;
        end
      end
      FIN_MUL_MAG: begin
        acc_d = alu_r[AW-1:0];
        aux_d = aux_q << 1;
        rem_d = rem_q >> 1;
        cnt_d = cnt_q - 1'b1;
        if (cnt_end) begin
          rem_d   = '0;
          root_d  = '0;
          cnt_d   = CNT_W'(R_W - 1);
          state_d = FIN_SQRT;
        end
      end
      FIN_SQRT: begin
        acc_d = acc_q << 2;
        if (ge) begin
          rem_d  = alu_r[RM_W-1:0];
          root_d = {root_q[R_W-2:0], 1'b1};
        end else begin
          rem_d  = {rem_q[RM_W-3:0], acc_q[D_W-1:D_W-2]};
          root_d = {root_q[R_W-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_end) begin
          state_d = FIN_MEAN_ADD;
        end
      end
      FIN_MEAN_ADD: begin
        quo_d   = alu_r[NW1-1:0];
        rem_d   = '0;
        div_d   = {n_q, 1'b0};
        cnt_d   = CNT_W'(NW1 - 1);
        state_d = FIN_MEAN_DIV;
      end
      FIN_MEAN_DIV, FIN_DEV_DIV: begin
        quo_d = q_next;
        rem_d = ge ? alu_r[RM_W-1:0] : {rem_q[RM_W-2:0], quo_q[NW1-1]};
        cnt_d = cnt_q - 1'b1;
        if (cnt_end) begin
          if (state_q == FIN_MEAN_DIV) begin
            mean_d  = neg_q ? q_neg[Q_W-1:0] : q_next[Q_W-1:0];
            quo_d   = NW1'(root_q);
            rem_d   = '0;
            div_d   = {1'b0, n_q};
            cnt_d   = CNT_W'(NW1 - 1);
            state_d = FIN_DEV_DIV;
          end else begin
            state_d = FIN_DONE;
          end
        end
      end
      FIN_DONE: begin
        if (res_take_i) begin
          state_d = FIN_IDLE;
        end
      end
      default: begin
        state_d = FIN_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FIN_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q   <= cnt_d;
    n_q     <= n_d;
    sumsq_q <= sumsq_d;
    mag_q   <= mag_d;
    neg_q   <= neg_d;
    min_q   <= min_d;
    max_q   <= max_d;
    ovf_q   <= ovf_d;
    last_q  <= last_d;
    empty_q <= empty_d;
    row_q   <= row_d;
    acc_q   <= acc_d;
    aux_q   <= aux_d;
    root_q  <= root_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    div_q   <= div_d;
    mean_q  <= mean_d;
  end

  assign idle_o      = (state_q == FIN_IDLE);
  assign res_valid_o = (state_q == FIN_DONE);
  assign status_o    = empty_q ? STATUS_EMPTY : (ovf_q ? STATUS_OVERFLOW : STATUS_OK);
  assign min_o       = empty_q ? '0 : min_q;
  assign max_o       = empty_q ? '0 : max_q;
  assign spread_o    = empty_q ? '0 : (max_q - min_q);
  assign mean_o      = empty_q ? '0 : mean_q;
  assign dev_o       = empty_q ? '0 : quo_q[Q_W-1:0];
  assign count_o     = empty_q ? '0 : n_q;
  assign row_o       = row_q;
  assign last_o      = last_q;

endmodule
